/* design/button_press_hold_events_assert.svh */
// ----------------------------------------------------------------------------
// Button press/hold event detector: assertion macros
// Shared property shapes for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_HOLD_EVENTS_ASSERT_SVH
`define BUTTON_PRESS_HOLD_EVENTS_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define BPHE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define BPHE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bphe_pkg.sv */
// ----------------------------------------------------------------------------
// Button press/hold event detector package
// Widths, register map, sequencer states and the divider status bundle.
// ----------------------------------------------------------------------------
package bphe_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int MASK_W      = 4;
    localparam int CNT_W       = 16;
    localparam int SLICE_W     = 16;
    localparam int REG_W       = 64;
    localparam int ADDR_W      = 6;
    localparam int IDX_LSB     = 3;
    localparam int IDX_W       = ADDR_W - IDX_LSB;
    localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int STEP_W      = $clog2(CNT_W);

    typedef enum logic [IDX_W-1:0] {
        REG_ACTIVE_LOW = 3'd0,
        REG_CLICK_EN   = 3'd1,
        REG_RELEASE_EN = 3'd2,
        REG_HOLD_EN    = 3'd3,
        REG_HOLD_THR   = 3'd4,
        REG_HOLD_PER   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_mod_status;

endpackage

/* design/button_press_hold_events.sv */
// ----------------------------------------------------------------------------
// Button press/hold/release event detector
// One tick in, one set of click/hold/release masks out, per button state
// kept in 16-bit press counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_raw_levels) carries one timer tick with
//   the raw pin level of each button. Output channel (o_valid/i_ready) returns
//   one transfer of click, hold and release masks for every tick.
//   The APB port sets polarity, event enables and the per button hold
//   threshold and repeat period (64-bit registers at byte address 8*index).
//   Buttons are handled one after another. A button that needs the hold
//   multiple test runs the shared serial remainder unit; any other button
//   is settled in the evaluate state alone. No new tick is taken until
//   the result is registered; the block is idle and ready again on the
//   same edge that loads the output register.
//   The result sits in an output register, so a new tick may be taken while
//   the receiver stalls; the block only waits at the end of the next tick if
//   the earlier result has still not been taken.
//   Reset clears the configuration registers, the press counters and both
//   channels.
// ----------------------------------------------------------------------------
`include "button_press_hold_events_assert.svh"

module button_press_hold_events (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bphe_pkg::MASK_W-1:0]   i_raw_levels,
    // event output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bphe_pkg::MASK_W-1:0]   o_click_mask,
    output logic [bphe_pkg::MASK_W-1:0]   o_hold_mask,
    output logic [bphe_pkg::MASK_W-1:0]   o_release_mask,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bphe_pkg::ADDR_W-1:0]   paddr,
    input  logic [bphe_pkg::REG_W-1:0]    pwdata,
    output logic [bphe_pkg::REG_W-1:0]    prdata,
    output logic                          pready
);

    bphe_pkg::t_state             r_state, n_state;
    bphe_pkg::t_reg_idx           reg_idx;
    bphe_pkg::t_mod_status        mod_status;

    logic [bphe_pkg::MASK_W-1:0]  r_active_low, r_click_en, r_release_en, r_hold_en;
    logic [bphe_pkg::REG_W-1:0]   r_hold_thr, r_hold_per;
    logic [bphe_pkg::CNT_W-1:0]   r_ticks [bphe_pkg::NUM_BUTTONS];

    logic [bphe_pkg::MASK_W-1:0]  r_levels;
    logic [bphe_pkg::BTN_W-1:0]   r_btn;
    logic [bphe_pkg::MASK_W-1:0]  r_click_acc, r_hold_acc, r_release_acc;
    logic                         r_out_valid;
    logic [bphe_pkg::MASK_W-1:0]  r_click_out, r_hold_out, r_release_out;

    logic                         cfg_wr;
    logic                         in_xfer, out_load;
    logic                         mod_start, btn_advance, last_btn;
    logic                         pressed;
    logic [bphe_pkg::CNT_W-1:0]   cur_count, n_count;
    logic [bphe_pkg::SLICE_W-1:0] thr, per, per_mag;
    logic                         above, need_mod;
    logic                         click_hit, hold_hit, release_hit;
    logic [bphe_pkg::MASK_W-1:0]  btn_bit;

    // Register write and read decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = bphe_pkg::t_reg_idx'(paddr[bphe_pkg::ADDR_W-1:bphe_pkg::IDX_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= '0;
            r_click_en   <= '0;
            r_release_en <= '0;
            r_hold_en    <= '0;
            r_hold_thr   <= '0;
            r_hold_per   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                bphe_pkg::REG_ACTIVE_LOW: r_active_low <= pwdata[bphe_pkg::MASK_W-1:0];
                bphe_pkg::REG_CLICK_EN:   r_click_en   <= pwdata[bphe_pkg::MASK_W-1:0];
                bphe_pkg::REG_RELEASE_EN: r_release_en <= pwdata[bphe_pkg::MASK_W-1:0];
                bphe_pkg::REG_HOLD_EN:    r_hold_en    <= pwdata[bphe_pkg::MASK_W-1:0];
                bphe_pkg::REG_HOLD_THR:   r_hold_thr   <= pwdata;
                bphe_pkg::REG_HOLD_PER:   r_hold_per   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bphe_pkg::REG_ACTIVE_LOW: prdata = bphe_pkg::REG_W'(r_active_low);
            bphe_pkg::REG_CLICK_EN:   prdata = bphe_pkg::REG_W'(r_click_en);
            bphe_pkg::REG_RELEASE_EN: prdata = bphe_pkg::REG_W'(r_release_en);
            bphe_pkg::REG_HOLD_EN:    prdata = bphe_pkg::REG_W'(r_hold_en);
            bphe_pkg::REG_HOLD_THR:   prdata = r_hold_thr;
            bphe_pkg::REG_HOLD_PER:   prdata = r_hold_per;
            default:                  prdata = '0;
        endcase
    end

    // Current button view
    assign pressed   = r_levels[r_btn] ^ r_active_low[r_btn];
    assign cur_count = r_ticks[r_btn];
    assign thr       = r_hold_thr[bphe_pkg::SLICE_W*r_btn +: bphe_pkg::SLICE_W];
    assign per       = r_hold_per[bphe_pkg::SLICE_W*r_btn +: bphe_pkg::SLICE_W];
    // negative period slice counts by its magnitude, negative threshold is always passed
    assign per_mag   = per[bphe_pkg::SLICE_W-1] ? (~per + 1'b1) : per;
    assign above     = thr[bphe_pkg::SLICE_W-1] | (cur_count > thr);
    assign need_mod  = pressed & r_hold_en[r_btn] & (per != '0) & above;

    assign click_hit   = pressed & (cur_count == '0) & r_click_en[r_btn];
    assign release_hit = ~pressed & (cur_count != '0) & r_release_en[r_btn];
    assign hold_hit    = need_mod & mod_status.rem_zero;
    assign n_count     = pressed ? cur_count + 1'b1 : '0;
    assign btn_bit     = bphe_pkg::MASK_W'(1) << r_btn;
    assign last_btn    = (r_btn == bphe_pkg::BTN_W'(bphe_pkg::NUM_BUTTONS - 1));

    // Shared remainder unit for the hold multiple test
    bphe_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (cur_count),
        .i_divisor  (per_mag),
        .o_status   (mod_status)
    );

    // Sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        mod_start   = 1'b0;
        btn_advance = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            bphe_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = bphe_pkg::S_EVAL;
                end
            end
            bphe_pkg::S_EVAL: begin
                if (need_mod) begin
                    mod_start = 1'b1;
                    n_state   = bphe_pkg::S_MOD;
                end else begin
                    btn_advance = 1'b1;
                    n_state     = last_btn ? bphe_pkg::S_DONE : bphe_pkg::S_EVAL;
                end
            end
            bphe_pkg::S_MOD: begin
                if (mod_status.done) begin
                    btn_advance = 1'b1;
                    n_state     = last_btn ? bphe_pkg::S_DONE : bphe_pkg::S_EVAL;
                end
            end
            bphe_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = bphe_pkg::S_IDLE;
                end
            end
            default: n_state = bphe_pkg::S_IDLE;
        endcase
    end

    assign o_ready = (r_state == bphe_pkg::S_IDLE);
    assign in_xfer = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bphe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk the buttons and update press counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn <= '0;
            for (int b = 0; b < bphe_pkg::NUM_BUTTONS; b++) begin
                r_ticks[b] <= '0;
            end
        end else if (in_xfer) begin
            r_btn <= '0;
        end else if (btn_advance) begin
            r_ticks[r_btn] <= n_count;
            r_btn          <= last_btn ? '0 : r_btn + 1'b1;
        end
    end

    // Latch the tick and gather event bits
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_levels      <= i_raw_levels;
            r_click_acc   <= '0;
            r_hold_acc    <= '0;
            r_release_acc <= '0;
        end else if (btn_advance) begin
            r_click_acc   <= r_click_acc   | (click_hit   ? btn_bit : '0);
            r_hold_acc    <= r_hold_acc    | (hold_hit    ? btn_bit : '0);
            r_release_acc <= r_release_acc | (release_hit ? btn_bit : '0);
        end
    end

    // Output register: hold the result until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_click_out   <= r_click_acc;
            r_hold_out    <= r_hold_acc;
            r_release_out <= r_release_acc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_click_mask   = r_click_out;
    assign o_hold_mask    = r_hold_out;
    assign o_release_mask = r_release_out;

    // Checks
    `BPHE_ASSERT_SAME(a_mod_done_in_mod, i_clk, i_rst_n, mod_status.done, r_state == bphe_pkg::S_MOD, "divider finished outside its wait state")
    `BPHE_ASSERT_SAME(a_idle_unit_quiet, i_clk, i_rst_n, o_ready, !mod_status.busy && r_btn == '0, "sequencer idle with work in flight")
    `BPHE_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_xfer, r_state == bphe_pkg::S_EVAL && r_btn == '0, "tick transfer did not start the walk")
    `BPHE_ASSERT_SAME(a_click_release_excl, i_clk, i_rst_n, o_valid, (o_click_mask & o_release_mask) == '0, "click and release on one button in one tick")

endmodule

/* design/bphe_mod_unit.sv */
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder of dividend by divisor is zero.
// ----------------------------------------------------------------------------
module bphe_mod_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bphe_pkg::CNT_W-1:0] i_dividend,
    input  logic [bphe_pkg::CNT_W-1:0] i_divisor,
    output bphe_pkg::t_mod_status      o_status
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [bphe_pkg::STEP_W-1:0] r_step, n_step;
    logic [bphe_pkg::CNT_W-1:0]  r_rem, n_rem;
    logic [bphe_pkg::CNT_W-1:0]  r_shift, n_shift;
    logic [bphe_pkg::CNT_W-1:0]  r_divisor, n_divisor;
    logic [bphe_pkg::CNT_W:0]    trial;
    logic [bphe_pkg::CNT_W:0]    diff;
    logic                        fits;

    // Trial subtract of the next partial remainder
    assign trial = {r_rem, r_shift[bphe_pkg::CNT_W-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign fits  = trial >= {1'b0, r_divisor};

    // Load on start, then one step per cycle
    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_step    = r_step;
        n_rem     = r_rem;
        n_shift   = r_shift;
        n_divisor = r_divisor;
        if (i_start) begin
            n_busy    = 1'b1;
            n_step    = '0;
            n_rem     = '0;
            n_shift   = i_dividend;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_rem   = fits ? diff[bphe_pkg::CNT_W-1:0] : trial[bphe_pkg::CNT_W-1:0];
            n_shift = {r_shift[bphe_pkg::CNT_W-2:0], 1'b0};
            n_step  = r_step + 1'b1;
            if (r_step == bphe_pkg::STEP_W'(bphe_pkg::CNT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_shift   <= n_shift;
        r_divisor <= n_divisor;
    end

    assign o_status.busy     = r_busy;
    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule
